/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion helpers
// shared concurrent check macros, clocked on clk_i and idle while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/mmnt_pkg.sv */
// ----------------------------------------------------------------------------
// mmnt_pkg
// shared sizes, codes and controller-to-datapath types for the triplet multiplier
// ----------------------------------------------------------------------------
package mmnt_pkg;

  localparam int MaxDim      = 8;
  localparam int ElementBits = 16;

  localparam int IdxBits   = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int AddrBits  = 2 * IdxBits;
  localparam int MemDepth  = 1 << AddrBits;
  localparam int ProdBits  = 2 * ElementBits;
  localparam int AccBits   = ProdBits + $clog2(MaxDim);

  // fixed field widths of the ports
  localparam int OpBits        = 2;
  localparam int IdxFieldBits  = 3;
  localparam int ElemFieldBits = 16;
  localparam int OutIdxBits    = 4;
  localparam int ValueBits     = 35;
  localparam int DimBits       = 4;
  localparam int CfgIdxBits    = 2;

  localparam logic [OpBits-1:0] OpWriteA  = 2'd0;
  localparam logic [OpBits-1:0] OpWriteB  = 2'd1;
  localparam logic [OpBits-1:0] OpCompute = 2'd2;

  localparam logic [CfgIdxBits-1:0] RegRowsUsed = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegColsUsed = 2'd1;

  localparam logic [DimBits-1:0] DimReset = 4'd8;

  typedef struct packed {
    logic               wr_a;
    logic               wr_b;
    logic               rd_en;
    logic [IdxBits-1:0] i;
    logic [IdxBits-1:0] j;
    logic [IdxBits-1:0] k;
    logic               first;
    logic               last;
    logic               flush;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_stat_t;

  // highest usable index for a dimension register, with 0 taken as 1
  function automatic logic [IdxBits-1:0] dim_last(logic [DimBits-1:0] v);
    logic [IdxBits-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > DimBits'(MaxDim)) begin
      r = IdxBits'(MaxDim - 1);
    end else begin
      r = IdxBits'(v - DimBits'(1));
    end
    return r;
  endfunction

endpackage

/* rtl/mmnt_dp.sv */
// ----------------------------------------------------------------------------
// mmnt_dp
// element memories, multiply-accumulate pipeline and result staging
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmnt_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  mmnt_pkg::dp_cmd_t                        cmd_i,
  output mmnt_pkg::dp_stat_t                       stat_o,
  input  logic [mmnt_pkg::IdxFieldBits-1:0]        row_index_i,
  input  logic [mmnt_pkg::IdxFieldBits-1:0]        col_index_i,
  input  logic signed [mmnt_pkg::ElemFieldBits-1:0] element_value_i,
  output logic                                     result_valid_o,
  output logic [mmnt_pkg::OutIdxBits-1:0]          out_row_o,
  output logic [mmnt_pkg::OutIdxBits-1:0]          out_col_o,
  output logic signed [mmnt_pkg::ValueBits-1:0]    out_value_o,
  output logic                                     is_last_o,
  output logic                                     is_empty_o
);
  import mmnt_pkg::*;

  logic signed [ElementBits-1:0] mem_a [MemDepth];
  logic signed [ElementBits-1:0] mem_b [MemDepth];

  logic signed [ElementBits-1:0] wr_elem;
  logic [AddrBits-1:0]           wr_addr;
  logic [AddrBits-1:0]           rd_addr_a;
  logic [AddrBits-1:0]           rd_addr_b;

  logic signed [ElementBits-1:0] rd_a_q;
  logic signed [ElementBits-1:0] rd_b_q;
  logic                          s1_v_q;
  logic [IdxBits-1:0]            s1_i_q;
  logic [IdxBits-1:0]            s1_j_q;
  logic                          s1_first_q;
  logic                          s1_last_q;

  logic signed [ProdBits-1:0]    prod_q;
  logic                          s2_v_q;
  logic [IdxBits-1:0]            s2_i_q;
  logic [IdxBits-1:0]            s2_j_q;
  logic                          s2_first_q;
  logic                          s2_last_q;

  logic signed [AccBits-1:0]     acc_q;
  logic signed [AccBits-1:0]     acc_sum;
  logic                          entry_done;
  logic                          entry_nz;

  logic                          pend_v_q;
  logic [OutIdxBits-1:0]         pend_row_q;
  logic [OutIdxBits-1:0]         pend_col_q;
  logic signed [AccBits-1:0]     pend_val_q;

  logic                          out_v_q;
  logic [OutIdxBits-1:0]         out_row_q;
  logic [OutIdxBits-1:0]         out_col_q;
  logic signed [AccBits-1:0]     out_val_q;
  logic                          out_last_q;
  logic                          out_empty_q;

  assign wr_elem   = ElementBits'(element_value_i);
  assign wr_addr   = {row_index_i[IdxBits-1:0], col_index_i[IdxBits-1:0]};
  assign rd_addr_a = {cmd_i.i, cmd_i.k};
  assign rd_addr_b = {cmd_i.k, cmd_i.j};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a[wr_addr] <= wr_elem;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b) begin
      mem_b[wr_addr] <= wr_elem;
    end
    if (cmd_i.rd_en) begin
      rd_b_q <= mem_b[rd_addr_b];
    end
  end

  // stage tags travel alongside the read data and the product
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      s1_i_q     <= cmd_i.i;
      s1_j_q     <= cmd_i.j;
      s1_first_q <= cmd_i.first;
      s1_last_q  <= cmd_i.last;
    end
    if (s1_v_q) begin
      prod_q     <= rd_a_q * rd_b_q;
      s2_i_q     <= s1_i_q;
      s2_j_q     <= s1_j_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
    end
  end

  assign acc_sum    = (s2_first_q ? AccBits'(0) : acc_q) + AccBits'(prod_q);
  assign entry_done = s2_v_q && s2_last_q;
  assign entry_nz   = acc_sum != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      acc_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      s1_v_q  <= cmd_i.rd_en;
      s2_v_q  <= s1_v_q;
      out_v_q <= 1'b0;
      if (s2_v_q) begin
        acc_q <= acc_sum;
      end
      if (cmd_i.flush) begin
        out_v_q  <= 1'b1;
        pend_v_q <= 1'b0;
      end else if (entry_done && entry_nz) begin
        // the held entry goes out once a later nonzero entry shows it is not last
        out_v_q  <= pend_v_q;
        pend_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.flush) begin
      out_row_q   <= pend_v_q ? pend_row_q : '0;
      out_col_q   <= pend_v_q ? pend_col_q : '0;
      out_val_q   <= pend_v_q ? pend_val_q : '0;
      out_last_q  <= 1'b1;
      out_empty_q <= !pend_v_q;
    end else if (entry_done && entry_nz) begin
      out_row_q   <= pend_row_q;
      out_col_q   <= pend_col_q;
      out_val_q   <= pend_val_q;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      pend_row_q  <= OutIdxBits'(s2_i_q) + OutIdxBits'(1);
      pend_col_q  <= OutIdxBits'(s2_j_q) + OutIdxBits'(1);
      pend_val_q  <= acc_sum;
    end
  end

  assign stat_o.pipe_busy = s1_v_q | s2_v_q;

  assign result_valid_o = out_v_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign out_value_o    = ValueBits'(out_val_q);
  assign is_last_o      = out_last_q;
  assign is_empty_o     = out_empty_q;

  `ASSERT_IMPL(a_flush_drained, cmd_i.flush, !s1_v_q && !s2_v_q)
  `ASSERT_IMPL(a_empty_is_last, out_v_q && out_empty_q, out_last_q)
  `ASSERT_NEXT(a_nz_held, entry_done && entry_nz && !cmd_i.flush, pend_v_q)

endmodule

/* rtl/mmnt_ctrl.sv */
// ----------------------------------------------------------------------------
// mmnt_ctrl
// request decode, dimension registers and the row/column/term sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmnt_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [mmnt_pkg::OpBits-1:0]       operation_i,
  input  logic [mmnt_pkg::IdxFieldBits-1:0] row_index_i,
  input  logic [mmnt_pkg::IdxFieldBits-1:0] col_index_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mmnt_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [mmnt_pkg::DimBits-1:0]      cfg_data_i,
  output mmnt_pkg::dp_cmd_t                 cmd_o,
  input  mmnt_pkg::dp_stat_t                stat_i
);
  import mmnt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRun   = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StFlush = 3'd3;
  localparam logic [2:0] StLast  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [IdxBits-1:0] i_q, i_d;
  logic [IdxBits-1:0] j_q, j_d;
  logic [IdxBits-1:0] k_q, k_d;
  logic [DimBits-1:0] rows_q;
  logic [DimBits-1:0] cols_q;
  logic [IdxBits-1:0] nr_last;
  logic [IdxBits-1:0] nc_last;
  logic               accept;
  logic               wr_in_range;

  assign nr_last     = dim_last(rows_q);
  assign nc_last     = dim_last(cols_q);
  assign busy        = state_q != StIdle;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign wr_in_range = ({1'b0, row_index_i} < (IdxFieldBits + 1)'(MaxDim)) &&
                       ({1'b0, col_index_i} < (IdxFieldBits + 1)'(MaxDim));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimReset;
      cols_q <= DimReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRowsUsed: rows_q <= cfg_data_i;
        RegColsUsed: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      StIdle: begin
        if (accept && operation_i == OpCompute) begin
          state_d = StRun;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      StRun: begin
        if (k_q == nc_last) begin
          k_d = '0;
          if (j_q == nc_last) begin
            j_d = '0;
            if (i_q == nr_last) begin
              i_d     = '0;
              state_d = StDrain;
            end else begin
              i_d = i_q + IdxBits'(1);
            end
          end else begin
            j_d = j_q + IdxBits'(1);
          end
        end else begin
          k_d = k_q + IdxBits'(1);
        end
      end
      StDrain: begin
        if (!stat_i.pipe_busy) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        state_d = StLast;
      end
      StLast: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.wr_a  = accept && operation_i == OpWriteA && wr_in_range;
    cmd_o.wr_b  = accept && operation_i == OpWriteB && wr_in_range;
    cmd_o.rd_en = state_q == StRun;
    cmd_o.i     = i_q;
    cmd_o.j     = j_q;
    cmd_o.k     = k_q;
    cmd_o.first = k_q == '0;
    cmd_o.last  = k_q == nc_last;
    cmd_o.flush = state_q == StFlush;
  end

  `ASSERT_IMPL(a_run_reads, state_q == StRun, cmd_o.rd_en && !cmd_o.flush)
  `ASSERT_IMPL(a_no_write_busy, busy, !cmd_o.wr_a && !cmd_o.wr_b)
  `ASSERT_NEXT(a_flush_then_last, state_q == StFlush, state_q == StLast && busy)

endmodule

/* rtl/matrix_multiply_nonzero_triplets.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_nonzero_triplets
// dense 8x8 signed matrix product reported as (row, col, value) triplets
//
// requests enter on start while busy is low. operation 0 and 1 write one
// element of A or B in the accepting cycle and leave busy low, so writes go
// in at one per cycle. operation 2 raises busy from the next cycle until
// the final result is out: one multiply-accumulate per cycle through a read,
// multiply and accumulate pipeline fed by simple dual-port element memories.
// every nonzero entry comes out in row-major order as a one-cycle strobe on
// result_valid_o, one entry behind its computation; the last one is marked
// with is_last_o in the final busy cycle. an all-zero product gives a single
// strobe with is_empty_o and is_last_o set. results cannot be held off.
// the config channel (index 0 rows, 1 cols) is always ready; the user must
// write it only while busy is low; the block itself does not enforce this.
// reset sets both dimensions to 8 and leaves the element memories unwritten.
// ----------------------------------------------------------------------------
module matrix_multiply_nonzero_triplets (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start,
  output logic                                      busy,
  input  logic [mmnt_pkg::OpBits-1:0]               operation_i,
  input  logic [mmnt_pkg::IdxFieldBits-1:0]         row_index_i,
  input  logic [mmnt_pkg::IdxFieldBits-1:0]         col_index_i,
  input  logic signed [mmnt_pkg::ElemFieldBits-1:0] element_value_i,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [mmnt_pkg::CfgIdxBits-1:0]           cfg_index_i,
  input  logic [mmnt_pkg::DimBits-1:0]              cfg_data_i,
  output logic                                      result_valid_o,
  output logic [mmnt_pkg::OutIdxBits-1:0]           out_row_o,
  output logic [mmnt_pkg::OutIdxBits-1:0]           out_col_o,
  output logic signed [mmnt_pkg::ValueBits-1:0]     out_value_o,
  output logic                                      is_last_o,
  output logic                                      is_empty_o
);
  import mmnt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mmnt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mmnt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .result_valid_o  (result_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .out_value_o     (out_value_o),
    .is_last_o       (is_last_o),
    .is_empty_o      (is_empty_o)
  );

endmodule
